@@ design/uifpq_pkg.sv @@
// Shared types and constants for the idle-framed UART packet queue.
// No dependencies; imported by every module of the block.
`default_nettype none
package uifpq_pkg;

  localparam int DEF_PACKET_BYTES = 64;
  localparam int DEF_PACKET_SLOTS = 8;
  localparam int DEF_TX_DEPTH     = 256;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int QCNT_W = 3;
  localparam int CNT_W  = 32;
  localparam int KIND_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RX_BYTE   = 3'd0,
    OP_LINE_IDLE = 3'd1,
    OP_TX_READY  = 3'd2,
    OP_TX_DONE   = 3'd3,
    OP_TX_PUSH   = 3'd4,
    OP_PKT_POP   = 3'd5,
    OP_NOP6      = 3'd6,
    OP_NOP7      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    CMD_RX, CMD_IDLE, CMD_TXRDY, CMD_TXDONE, CMD_PUSH, CMD_POP, CMD_NOP
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t          code;
    logic [BYTE_W-1:0]  data;
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS    = 2'd0,
    KIND_LINE_BYTE = 2'd1,
    KIND_PKT_BYTE  = 2'd2,
    KIND_POP_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EMIT, ST_TXD, ST_PLEN, ST_PADDR, ST_PDATA
  } state_t;

endpackage
`default_nettype wire

@@ design/uart_idle_framed_packet_queue.sv @@
// Top level of the idle-framed UART packet queue.
// Depends on uifpq_pkg, uifpq_front and uifpq_engine.
//
// Input channel (in_*): one item per UART event or consumer request. in_tuser
// carries the op (rx byte, line idle, tx ready, tx complete, tx push, packet
// pop), in_tdata the byte. A two-entry command queue decouples acceptance
// from execution, so input is still accepted while the back end drains results.
// Output channel (out_*): one result per item, or one result per byte for a
// packet pop; tlast marks the final result of the item.
// Status items pass from the command queue through execution and the emit state
// into the result register; a tx ready that sends a byte does the same. A packet
// pop reads the slot length, then fetches each byte through the registered read
// of the packet memory. The back end finishes one command before it takes the next.
// Reset (rst_n low, synchronous) empties both rings, clears the counters and
// flags and drops queued commands; memories keep their contents.
// While out_tready is low the result register holds and the back end waits;
// the command queue keeps accepting until it is full.
`default_nettype none
module uart_idle_framed_packet_queue #(
  parameter int PACKET_BYTES = uifpq_pkg::DEF_PACKET_BYTES,
  parameter int PACKET_SLOTS = uifpq_pkg::DEF_PACKET_SLOTS,
  parameter int TX_DEPTH     = uifpq_pkg::DEF_TX_DEPTH
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,   // [7:0] data
  input  wire  [2:0]   in_tuser,   // [2:0] op
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [119:0] out_tdata,  // byte_out, packet_length, tx_busy, tx_push_refused,
                                   // queued_packets, bytes_received, packets_received,
                                   // packets_dropped, zero fill
  output logic [1:0]   out_tuser,  // [1:0] kind
  output logic         out_tlast
);
  import uifpq_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] byte_out;
  logic [LEN_W-1:0]  plen;
  logic busy, refused;
  logic [QCNT_W-1:0] queued;
  logic [CNT_W-1:0]  nb, np, nd;

  uifpq_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_op(in_tuser), .in_data(in_tdata),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  uifpq_engine #(
    .PACKET_BYTES(PACKET_BYTES), .PACKET_SLOTS(PACKET_SLOTS), .TX_DEPTH(TX_DEPTH)
  ) u_engine (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(kind), .out_byte(byte_out), .out_last(out_tlast),
    .out_plen(plen), .out_busy(busy), .out_refused(refused),
    .out_queued(queued), .out_bytes(nb), .out_pkts(np), .out_drops(nd)
  );

  assign out_tuser = kind;
  assign out_tdata = {4'd0, nd, np, nb, queued, refused, busy, plen, byte_out};
endmodule
`default_nettype wire

@@ design/uifpq_front.sv @@
// Front end: decodes input items into commands and holds them in a two-entry queue.
// Depends on uifpq_pkg.
`default_nettype none
module uifpq_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire [uifpq_pkg::OP_W-1:0]   in_op,
  input  wire [uifpq_pkg::BYTE_W-1:0] in_data,
  output logic                        cmd_valid,
  output uifpq_pkg::cmd_t             cmd,
  input  wire                         cmd_pop
);
  import uifpq_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.data = in_data;
    unique case (op_t'(in_op))
      OP_RX_BYTE:   dec.code = CMD_RX;
      OP_LINE_IDLE: dec.code = CMD_IDLE;
      OP_TX_READY:  dec.code = CMD_TXRDY;
      OP_TX_DONE:   dec.code = CMD_TXDONE;
      OP_TX_PUSH:   dec.code = CMD_PUSH;
      OP_PKT_POP:   dec.code = CMD_POP;
      default:      dec.code = CMD_NOP;
    endcase
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !cmd_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!push && cmd_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end
endmodule
`default_nettype wire

@@ design/uifpq_engine.sv @@
// Back end: packet ring, transmit ring, counters and the result register.
// Depends on uifpq_pkg; takes commands from uifpq_front.
`default_nettype none
module uifpq_engine #(
  parameter int PACKET_BYTES = uifpq_pkg::DEF_PACKET_BYTES,
  parameter int PACKET_SLOTS = uifpq_pkg::DEF_PACKET_SLOTS,
  parameter int TX_DEPTH     = uifpq_pkg::DEF_TX_DEPTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cmd_valid,
  input  uifpq_pkg::cmd_t              cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [uifpq_pkg::KIND_W-1:0] out_kind,
  output logic [uifpq_pkg::BYTE_W-1:0] out_byte,
  output logic                         out_last,
  output logic [uifpq_pkg::LEN_W-1:0]  out_plen,
  output logic                         out_busy,
  output logic                         out_refused,
  output logic [uifpq_pkg::QCNT_W-1:0] out_queued,
  output logic [uifpq_pkg::CNT_W-1:0]  out_bytes,
  output logic [uifpq_pkg::CNT_W-1:0]  out_pkts,
  output logic [uifpq_pkg::CNT_W-1:0]  out_drops
);
  import uifpq_pkg::*;

  localparam int SW = $clog2(PACKET_SLOTS);
  localparam int LW = $clog2(PACKET_BYTES + 1);
  localparam int AW = $clog2(PACKET_SLOTS * PACKET_BYTES);
  localparam int TW = $clog2(TX_DEPTH);
  localparam logic [SW-1:0] SLOT_LAST = SW'(PACKET_SLOTS - 1);
  localparam logic [TW-1:0] TX_LAST   = TW'(TX_DEPTH - 1);
  localparam logic [LW-1:0] PB        = LW'(PACKET_BYTES);
  localparam logic [AW-1:0] PB_A      = AW'(PACKET_BYTES);
  localparam logic [SW:0]   SLOTS_X   = (SW+1)'(PACKET_SLOTS);

  logic [BYTE_W-1:0] pkt_mem [PACKET_SLOTS*PACKET_BYTES];
  logic [LEN_W-1:0]  len_mem [PACKET_SLOTS];
  logic [BYTE_W-1:0] tx_mem  [TX_DEPTH];

  state_t state_r, state_nxt;
  logic [SW-1:0] swp_r, srp_r, pop_slot_r;
  logic [LW-1:0] fill_r, idx_r, len_r;
  logic [TW-1:0] twp_r, trp_r;
  logic busy_r, rdy_en_r, cpl_en_r;
  logic [CNT_W-1:0] cnt_b_r, cnt_p_r, cnt_d_r;
  kind_t pend_kind_r;
  logic  pend_ref_r;

  logic [BYTE_W-1:0] pkt_rd_r, tx_rd_r;
  logic [LEN_W-1:0]  len_rd_r;

  logic out_valid_r;
  logic [KIND_W-1:0] o_kind_r;
  logic [BYTE_W-1:0] o_byte_r;
  logic o_last_r, o_busy_r, o_ref_r;
  logic [LEN_W-1:0] o_plen_r;
  logic [QCNT_W-1:0] o_q_r;
  logic [CNT_W-1:0] o_b_r, o_p_r, o_d_r;

  logic out_free;
  logic [SW-1:0] swp_inc, srp_inc;
  logic [TW-1:0] twp_inc, trp_inc;
  logic [SW:0]   qdiff;
  logic [AW-1:0] pkt_waddr, pkt_raddr;
  logic [LW-1:0] len_clamp;

  assign out_free = !out_valid_r || out_ready;
  assign swp_inc  = (swp_r == SLOT_LAST) ? '0 : swp_r + 1'b1;
  assign srp_inc  = (srp_r == SLOT_LAST) ? '0 : srp_r + 1'b1;
  assign twp_inc  = (twp_r == TX_LAST) ? '0 : twp_r + 1'b1;
  assign trp_inc  = (trp_r == TX_LAST) ? '0 : trp_r + 1'b1;
  assign qdiff    = (swp_r >= srp_r) ? {1'b0, swp_r} - {1'b0, srp_r}
                                     : {1'b0, swp_r} + SLOTS_X - {1'b0, srp_r};
  assign pkt_waddr = AW'(swp_r) * PB_A + AW'(fill_r);
  assign pkt_raddr = AW'(pop_slot_r) * PB_A + AW'(idx_r);

  always_comb begin
    if (len_rd_r == '0) len_clamp = LW'(1);
    else if ({1'b0, len_rd_r} > 8'(PACKET_BYTES)) len_clamp = PB;
    else len_clamp = LW'(len_rd_r);
  end

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    unique case (state_r)
      ST_IDLE: if (cmd_valid) begin
        cmd_pop = 1'b1;
        if (cmd.code == CMD_TXRDY && rdy_en_r && trp_r != twp_r) state_nxt = ST_TXD;
        else if (cmd.code == CMD_POP && srp_r != swp_r) state_nxt = ST_PLEN;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      ST_TXD:   if (out_free) state_nxt = ST_IDLE;
      ST_PLEN:  state_nxt = ST_PADDR;
      ST_PADDR: state_nxt = ST_PDATA;
      ST_PDATA: if (out_free) state_nxt = (idx_r + 1'b1 == len_r) ? ST_IDLE : ST_PADDR;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      swp_r    <= '0;
      srp_r    <= '0;
      fill_r   <= '0;
      twp_r    <= '0;
      trp_r    <= '0;
      busy_r   <= 1'b0;
      rdy_en_r <= 1'b0;
      cpl_en_r <= 1'b0;
      cnt_b_r  <= '0;
      cnt_p_r  <= '0;
      cnt_d_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (cmd_valid) begin
          pend_kind_r <= KIND_STATUS;
          pend_ref_r  <= 1'b0;
          case (cmd.code)
            CMD_RX: if (fill_r < PB) begin
              fill_r  <= fill_r + 1'b1;
              cnt_b_r <= cnt_b_r + 1'b1;
            end
            CMD_IDLE: if (fill_r != '0) begin
              if (swp_inc != srp_r) begin
                swp_r   <= swp_inc;
                cnt_p_r <= cnt_p_r + 1'b1;
              end else begin
                cnt_d_r <= cnt_d_r + 1'b1;
              end
              fill_r <= '0;
            end
            CMD_TXRDY: if (rdy_en_r) begin
              if (trp_r != twp_r) begin
                trp_r <= trp_inc;
              end else begin
                rdy_en_r <= 1'b0;
                cpl_en_r <= 1'b1;
              end
            end
            CMD_TXDONE: if (cpl_en_r) begin
              cpl_en_r <= 1'b0;
              busy_r   <= (trp_r != twp_r);
              if (trp_r != twp_r) rdy_en_r <= 1'b1;
            end
            CMD_PUSH: begin
              if (twp_inc == trp_r) begin
                pend_ref_r <= 1'b1;
              end else begin
                twp_r <= twp_inc;
                if (!busy_r) begin
                  busy_r   <= 1'b1;
                  rdy_en_r <= 1'b1;
                end
              end
            end
            CMD_POP: if (srp_r == swp_r) pend_kind_r <= KIND_POP_EMPTY;
            default: ;
          endcase
        end
        ST_PLEN: begin
          len_r      <= len_clamp;
          idx_r      <= '0;
          pop_slot_r <= srp_r;
        end
        ST_PDATA: if (out_free) idx_r <= idx_r + 1'b1;
        default: ;
      endcase
      // advance read slot once the packet is in flight so status already shows removal
      if (state_r == ST_PLEN) srp_r <= srp_inc;
      if ((state_r == ST_EMIT || state_r == ST_TXD || state_r == ST_PDATA) && out_free)
        out_valid_r <= 1'b1;
      else if (out_ready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT || state_r == ST_TXD || state_r == ST_PDATA) begin
      if (out_free) begin
        o_busy_r <= busy_r;
        o_q_r    <= QCNT_W'(qdiff);
        o_b_r    <= cnt_b_r;
        o_p_r    <= cnt_p_r;
        o_d_r    <= cnt_d_r;
        o_ref_r  <= (state_r == ST_EMIT) ? pend_ref_r : 1'b0;
        unique case (state_r)
          ST_EMIT: begin
            o_kind_r <= pend_kind_r;
            o_byte_r <= '0;
            o_last_r <= 1'b1;
            o_plen_r <= '0;
          end
          ST_TXD: begin
            o_kind_r <= KIND_LINE_BYTE;
            o_byte_r <= tx_rd_r;
            o_last_r <= 1'b1;
            o_plen_r <= '0;
          end
          default: begin
            o_kind_r <= KIND_PKT_BYTE;
            o_byte_r <= pkt_rd_r;
            o_last_r <= (idx_r + 1'b1 == len_r);
            o_plen_r <= LEN_W'(len_r);
          end
        endcase
      end
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && cmd.code == CMD_RX && fill_r < PB)
      pkt_mem[pkt_waddr] <= cmd.data;
    if (state_r == ST_PADDR) pkt_rd_r <= pkt_mem[pkt_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && cmd.code == CMD_IDLE && fill_r != '0
        && swp_inc != srp_r)
      len_mem[swp_r] <= LEN_W'(fill_r);
    if (state_r == ST_IDLE) len_rd_r <= len_mem[srp_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && cmd.code == CMD_PUSH && twp_inc != trp_r)
      tx_mem[twp_r] <= cmd.data;
    if (state_r == ST_IDLE) tx_rd_r <= tx_mem[trp_r];
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = o_kind_r;
  assign out_byte    = o_byte_r;
  assign out_last    = o_last_r;
  assign out_plen    = o_plen_r;
  assign out_busy    = o_busy_r;
  assign out_refused = o_ref_r;
  assign out_queued  = o_q_r;
  assign out_bytes   = o_b_r;
  assign out_pkts    = o_p_r;
  assign out_drops   = o_d_r;
endmodule
`default_nettype wire

@@ sim/tb_uart_idle_framed_packet_queue.sv @@
// Self-checking bench for the idle-framed UART packet queue.
// Predicts every result item from its own model of the rings and counters; uses uifpq_pkg.
`timescale 1ns / 1ps
module tb_uart_idle_framed_packet_queue;
  import uifpq_pkg::*;

  localparam int PKT_BYTES = 64;
  localparam int PKT_SLOTS = 8;
  localparam int TXD = 256;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic        last;
    logic [6:0]  plen;
    logic        busy;
    logic        refused;
    logic [2:0]  queued;
    logic [31:0] nbytes;
    logic [31:0] npkts;
    logic [31:0] ndrop;
  } res_t;

  class queue_scoreboard;
    logic [7:0] pkt_mem [PKT_SLOTS*PKT_BYTES];
    logic [6:0] pkt_len [PKT_SLOTS];
    logic [7:0] tx_mem [TXD];
    int unsigned wslot, rslot, fill, twp, trp;
    bit busy, rdy_en, done_en;
    logic [31:0] nbytes, npkts, ndrop;
    res_t pending[$];
    int errors, checked, pops;

    function void clear();
      wslot = 0; rslot = 0; fill = 0; twp = 0; trp = 0;
      busy = 0; rdy_en = 0; done_en = 0;
      nbytes = 0; npkts = 0; ndrop = 0;
      errors = 0; checked = 0; pops = 0;
      pending.delete();
    endfunction

    function void emit(logic [1:0] k, logic [7:0] b, bit l, logic [6:0] pl, bit rf);
      res_t r;
      r.kind = k; r.byte_out = b; r.last = l; r.plen = pl; r.busy = busy;
      r.refused = rf; r.queued = 3'((wslot + PKT_SLOTS - rslot) % PKT_SLOTS);
      r.nbytes = nbytes; r.npkts = npkts; r.ndrop = ndrop;
      pending.push_back(r);
    endfunction

    function void note_input(op_t op, logic [7:0] d);
      int unsigned nx, sl, ln;
      bit rf;
      rf = 0;
      case (op)
        OP_RX_BYTE: if (fill < PKT_BYTES) begin
          pkt_mem[wslot*PKT_BYTES+fill] = d; fill++; nbytes++;
        end
        OP_LINE_IDLE: if (fill > 0) begin
          nx = (wslot + 1) % PKT_SLOTS;
          if (nx != rslot) begin
            pkt_len[wslot] = 7'(fill); wslot = nx; npkts++;
          end else ndrop++;
          fill = 0;
        end
        OP_TX_READY: if (rdy_en) begin
          if (trp != twp) begin
            sl = trp; trp = (trp + 1) % TXD;
            emit(KIND_LINE_BYTE, tx_mem[sl], 1, 0, 0);
            return;
          end
          rdy_en = 0; done_en = 1;
        end
        OP_TX_DONE: if (done_en) begin
          done_en = 0; busy = 0;
          if (trp != twp) begin busy = 1; rdy_en = 1; end
        end
        OP_TX_PUSH: begin
          nx = (twp + 1) % TXD;
          if (nx == trp) rf = 1;
          else begin
            tx_mem[twp] = d; twp = nx;
            if (!busy) begin busy = 1; rdy_en = 1; end
          end
        end
        OP_PKT_POP: begin
          if (rslot == wslot) begin
            emit(KIND_POP_EMPTY, 0, 1, 0, 0);
            return;
          end
          sl = rslot; ln = pkt_len[sl];
          if (ln > PKT_BYTES) ln = PKT_BYTES;
          if (ln == 0) ln = 1;
          rslot = (rslot + 1) % PKT_SLOTS;
          pops++;
          for (int i = 0; i < ln; i++)
            emit(KIND_PKT_BYTE, pkt_mem[sl*PKT_BYTES+i], (i + 1 == ln), 7'(ln), 0);
          return;
        end
        default: ;
      endcase
      emit(KIND_STATUS, 0, 1, 0, rf);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        $error("unexpected result item kind=%0d", got.kind);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.kind !== e.kind) begin $error("kind exp %0d got %0d", e.kind, got.kind); errors++; end
      if (got.byte_out !== e.byte_out) begin
        $error("byte_out exp %0h got %0h", e.byte_out, got.byte_out); errors++; end
      if (got.last !== e.last) begin $error("last exp %0d got %0d", e.last, got.last); errors++; end
      if (got.plen !== e.plen) begin
        $error("packet_length exp %0d got %0d", e.plen, got.plen); errors++; end
      if (got.busy !== e.busy) begin $error("tx_busy exp %0d got %0d", e.busy, got.busy); errors++; end
      if (got.refused !== e.refused) begin
        $error("tx_push_refused exp %0d got %0d", e.refused, got.refused); errors++; end
      if (got.queued !== e.queued) begin
        $error("queued_packets exp %0d got %0d", e.queued, got.queued); errors++; end
      if (got.nbytes !== e.nbytes) begin
        $error("bytes_received exp %0d got %0d", e.nbytes, got.nbytes); errors++; end
      if (got.npkts !== e.npkts) begin
        $error("packets_received exp %0d got %0d", e.npkts, got.npkts); errors++; end
      if (got.ndrop !== e.ndrop) begin
        $error("packets_dropped exp %0d got %0d", e.ndrop, got.ndrop); errors++; end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [7:0] in_tdata = 0;
  logic [2:0] in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [119:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  queue_scoreboard sb;
  int cycles = 0;
  int long_hold = 0;
  int items_sent = 0;
  bit stim_done = 0;

  always #5 clk = ~clk;

  uart_idle_framed_packet_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // Sample results at the rising edge.
  always @(posedge clk) begin
    res_t r;
    cycles++;
    if (rst_n && out_tvalid && out_tready) begin
      r.kind = out_tuser; r.last = out_tlast;
      r.byte_out = out_tdata[7:0];
      r.plen = out_tdata[14:8];
      r.busy = out_tdata[15];
      r.refused = out_tdata[16];
      r.queued = out_tdata[19:17];
      r.nbytes = out_tdata[51:20];
      r.npkts = out_tdata[83:52];
      r.ndrop = out_tdata[115:84];
      sb.check_result(r);
    end
    if (cycles > LIMIT) begin
      $display("FAIL uart_idle_framed_packet_queue");
      $finish;
    end
  end

  // Receiver stall pattern, with one long hold-off requested by the sender.
  initial begin
    int ph;
    ph = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        out_tready <= 0;
        long_hold--;
      end else begin
        ph++;
        out_tready <= !rst_n ? 0 : ((ph % 37) < 20) ? 1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send_item(op_t op, logic [7:0] d);
    in_tuser <= op;
    in_tdata <= d;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, d);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic gap();
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic send_packet(int n);
    for (int i = 0; i < n; i++) begin
      send_item(OP_RX_BYTE, 8'($urandom));
      gap();
    end
    send_item(OP_LINE_IDLE, 8'($urandom));
  endtask

  initial begin
    int r, n;
    sb = new();
    sb.clear();
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: empty pop, idle with no bytes, ignored tx events, unused ops.
    send_item(OP_PKT_POP, 8'h00);
    send_item(OP_LINE_IDLE, 8'hff);
    send_item(OP_TX_READY, 8'h00);
    send_item(OP_TX_DONE, 8'h00);
    send_item(OP_NOP6, 8'hff);
    send_item(OP_NOP7, 8'h00);
    send_item(OP_RX_BYTE, 8'h00);
    send_item(OP_RX_BYTE, 8'hff);
    send_item(OP_LINE_IDLE, 8'h00);
    send_item(OP_PKT_POP, 8'h00);
    send_item(OP_TX_PUSH, 8'ha5);
    send_item(OP_TX_PUSH, 8'h5a);
    send_item(OP_TX_READY, 8'h00);
    send_item(OP_TX_READY, 8'h00);
    send_item(OP_TX_READY, 8'h00);
    send_item(OP_TX_DONE, 8'h00);
    send_item(OP_PKT_POP, 8'h00);
    in_tvalid <= 0;

    // Long hold-off: overflow a 64-byte packet while results back up.
    long_hold = 300;
    send_packet(70);
    // Fill the ring; the last two of these eight packets are dropped.
    for (int i = 0; i < 8; i++) send_packet($urandom_range(1, 4));
    for (int i = 0; i < 8; i++) send_item(OP_PKT_POP, 8'h00);

    // A few tx bytes, then drain them and finish the transfer.
    for (int i = 0; i < 4; i++) send_item(OP_TX_PUSH, 8'($urandom));
    for (int i = 0; i < 6; i++) send_item(OP_TX_READY, 8'h00);
    send_item(OP_TX_DONE, 8'h00);

    // Random: mostly framed packets and tx traffic, some noise.
    while (items_sent < 180) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 66) : $urandom_range(1, 6);
        send_packet(n);
      end else if (r < 6) send_item(OP_PKT_POP, 8'($urandom));
      else if (r == 6) send_item(OP_TX_PUSH, 8'($urandom));
      else if (r == 7) send_item(op_t'($urandom_range(2, 3)), 8'($urandom));
      else send_item(op_t'($urandom_range(0, 7)), 8'($urandom));
      gap();
    end
    in_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d items; checked %0d results including %0d packet pops.",
             items_sent, sb.checked, sb.pops);
    $display("Covered overlong packets, slot overflow drops, tx send and complete events.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS uart_idle_framed_packet_queue");
    end else begin
      $display("FAIL uart_idle_framed_packet_queue");
    end
    $finish;
  end
endmodule
